>>> rtl/obm_pkg.sv
// Shared types, constants and register map of the one-wire bus master.
package obm_pkg;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned TickW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitIdxW   = 3;
  localparam int unsigned PaddrW    = 5;
  localparam int unsigned PdataW    = 32;

  localparam logic [TickW-1:0] PresenceHoldTicks = TickW'(60);
  localparam logic [TickW-1:0] ResetTailTicks    = TickW'(410);

  typedef enum logic [RegIdxW-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_WRITE_ONE_LOW = 3'd2,
    REG_WRITE_ZERO_LOW= 3'd3,
    REG_SLOT_TAIL     = 3'd4,
    REG_RECOVERY      = 3'd5,
    REG_READ_LOW      = 3'd6,
    REG_READ_SAMPLE   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_PRES = 4'd3,
    PH_RST_HOLD = 4'd4,
    PH_RST_HIGH = 4'd5,
    PH_RST_TAIL = 4'd6,
    PH_WR_LOW   = 4'd7,
    PH_WR_REL   = 4'd8,
    PH_RD_LOW   = 4'd9,
    PH_RD_WAIT  = 4'd10,
    PH_RD_TAIL  = 4'd11
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0] reset_low_ticks;
    logic [TickW-1:0] presence_wait_ticks;
    logic [TickW-1:0] write_one_low_ticks;
    logic [TickW-1:0] write_zero_low_ticks;
    logic [TickW-1:0] slot_tail_ticks;
    logic [TickW-1:0] recovery_ticks;
    logic [TickW-1:0] read_low_ticks;
    logic [TickW-1:0] read_sample_ticks;
  } cfg_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_byte;
  } res_t;

  localparam cfg_t CfgReset = '{
    reset_low_ticks:      TickW'(480),
    presence_wait_ticks:  TickW'(60),
    write_one_low_ticks:  TickW'(10),
    write_zero_low_ticks: TickW'(60),
    slot_tail_ticks:      TickW'(55),
    recovery_ticks:       TickW'(5),
    read_low_ticks:       TickW'(2),
    read_sample_ticks:    TickW'(10)
  };

endpackage

>>> rtl/obm_in_if.sv
// Input channel: one timing tick word with operation, data byte and line level.
interface obm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       line_level;

  modport source (output valid, output operation, output data_byte, output line_level,
                  input ready);
  modport sink (input valid, input operation, input data_byte, input line_level,
                output ready);
endinterface

>>> rtl/obm_out_if.sv
// Output channel: one result word per tick with drive, busy, done and read byte.
interface obm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output read_byte, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input read_byte, output ready);
endinterface

>>> rtl/onewire_bus_master_unit.sv
// One-wire bus master: the input channel carries one timing tick per word with the
// operation to start (reset, byte write, byte read or plain tick), the byte to send
// and the bus level sampled on that tick. Each accepted word yields exactly one
// result word with the line drive, busy and done flags and the last byte read.
// The user must write the eight timing registers (byte address 4*i) over the APB
// port only while idle, which the block does not enforce. A tick's result sits in
// the result register from the cycle after it is accepted. Throughput: one tick per
// clock cycle unless stalled; the phase, counter and shifter update on acceptance.
// Reset: the sequencer returns to idle, counters and bytes clear, the timing
// registers take their default values and no result is pending.
// Stall: while the receiver holds off, the one result word waits in the result
// register and the input ready drops; state does not advance until it is taken.
module onewire_bus_master_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  obm_in_if.sink                      in_i,
  obm_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [obm_pkg::PaddrW-1:0]  paddr,
  input  logic [obm_pkg::PdataW-1:0]  pwdata,
  output logic [obm_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import obm_pkg::*;

  cfg_t cfg;
  res_t res_new;
  res_t res_held;
  logic in_ready;
  logic accept;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  obm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  obm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (in_i.operation),
    .data_byte_i  (in_i.data_byte),
    .line_level_i (in_i.line_level),
    .cfg_i        (cfg),
    .res_o        (res_new)
  );

  obm_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .res_i       (res_new),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res_held)
  );

  assign out_o.drive_low = res_held.drive_low;
  assign out_o.busy_res  = res_held.busy_res;
  assign out_o.done_res  = res_held.done_res;
  assign out_o.read_byte = res_held.read_byte;

endmodule

>>> rtl/obm_cfg.sv
// APB-style register file holding the eight timing registers.
module obm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [obm_pkg::PaddrW-1:0]    paddr,
  input  logic [obm_pkg::PdataW-1:0]    pwdata,
  output logic [obm_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  output obm_pkg::cfg_t                 cfg_o
);
  import obm_pkg::*;

  cfg_t                cfg_q, cfg_d;
  logic                wr_en;
  logic [RegIdxW-1:0]  idx;
  logic [TickW-1:0]    wval;
  logic [TickW-1:0]    rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[PaddrW-1:2];
  assign wval   = pwdata[TickW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx_e'(idx))
        REG_RESET_LOW:      cfg_d.reset_low_ticks      = wval;
        REG_PRESENCE_WAIT:  cfg_d.presence_wait_ticks  = wval;
        REG_WRITE_ONE_LOW:  cfg_d.write_one_low_ticks  = wval;
        REG_WRITE_ZERO_LOW: cfg_d.write_zero_low_ticks = wval;
        REG_SLOT_TAIL:      cfg_d.slot_tail_ticks      = wval;
        REG_RECOVERY:       cfg_d.recovery_ticks       = wval;
        REG_READ_LOW:       cfg_d.read_low_ticks       = wval;
        REG_READ_SAMPLE:    cfg_d.read_sample_ticks    = wval;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(idx))
      REG_RESET_LOW:      rval = cfg_q.reset_low_ticks;
      REG_PRESENCE_WAIT:  rval = cfg_q.presence_wait_ticks;
      REG_WRITE_ONE_LOW:  rval = cfg_q.write_one_low_ticks;
      REG_WRITE_ZERO_LOW: rval = cfg_q.write_zero_low_ticks;
      REG_SLOT_TAIL:      rval = cfg_q.slot_tail_ticks;
      REG_RECOVERY:       rval = cfg_q.recovery_ticks;
      REG_READ_LOW:       rval = cfg_q.read_low_ticks;
      REG_READ_SAMPLE:    rval = cfg_q.read_sample_ticks;
      default:            rval = '0;
    endcase
  end

  assign prdata = {{(PdataW-TickW){1'b0}}, rval};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/obm_seq.sv
// Bus sequencer: phase state machine, tick counter and bit shifter, one tick per word.
module obm_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [1:0]                  operation_i,
  input  logic [obm_pkg::ByteW-1:0]   data_byte_i,
  input  logic                        line_level_i,
  input  obm_pkg::cfg_t               cfg_i,
  output obm_pkg::res_t               res_o
);
  import obm_pkg::*;

  phase_e              phase_q, phase_d, phase_s;
  logic [TickW-1:0]    cnt_q, cnt_d, cnt_s;
  logic [BitIdxW-1:0]  bidx_q, bidx_d, bidx_s;
  logic [ByteW-1:0]    sb_q, sb_d, sb_s;
  logic [ByteW-1:0]    asm_q, asm_d;
  logic                done;
  logic                drive;
  logic                busy;
  logic [TickW-1:0]    dur;
  logic [TickW-1:0]    cnt_inc;
  logic                fin;
  logic                one;

  // Start of an operation: this tick is already its first tick.
  always_comb begin
    phase_s = phase_q;
    cnt_s   = cnt_q;
    bidx_s  = bidx_q;
    sb_s    = sb_q;
    if (phase_q == PH_IDLE && op_e'(operation_i) != OP_TICK) begin
      cnt_s  = '0;
      bidx_s = '0;
      case (op_e'(operation_i))
        OP_RESET: phase_s = PH_RST_LOW;
        OP_WRITE: begin
          sb_s    = data_byte_i;
          phase_s = PH_WR_LOW;
        end
        OP_READ: begin
          sb_s    = '0;
          phase_s = PH_RD_LOW;
        end
        default: phase_s = phase_q;
      endcase
    end
  end

  assign one = sb_s[0];

  // Interval length of the current phase.
  always_comb begin
    case (phase_s)
      PH_RST_LOW:  dur = cfg_i.reset_low_ticks;
      PH_RST_WAIT: dur = cfg_i.presence_wait_ticks;
      PH_RST_HOLD: dur = PresenceHoldTicks;
      PH_RST_TAIL: dur = ResetTailTicks;
      PH_WR_LOW:   dur = one ? cfg_i.write_one_low_ticks : cfg_i.write_zero_low_ticks;
      PH_WR_REL:   dur = one ? cfg_i.slot_tail_ticks : cfg_i.recovery_ticks;
      PH_RD_LOW:   dur = cfg_i.read_low_ticks;
      PH_RD_WAIT:  dur = cfg_i.read_sample_ticks;
      PH_RD_TAIL:  dur = cfg_i.slot_tail_ticks;
      default:     dur = '0;
    endcase
  end

  // A zero-length interval, or a counter wrap, ends after one tick.
  assign cnt_inc = cnt_s + TickW'(1);
  assign fin     = (cnt_inc >= dur) || (cnt_inc == '0);

  // Outputs of this tick.
  always_comb begin
    drive = (phase_s == PH_RST_LOW) || (phase_s == PH_WR_LOW) || (phase_s == PH_RD_LOW);
    busy  = (phase_s != PH_IDLE);
  end

  // Next state.
  always_comb begin
    phase_d = phase_s;
    cnt_d   = cnt_s;
    bidx_d  = bidx_s;
    sb_d    = sb_s;
    asm_d   = asm_q;
    done    = 1'b0;
    case (phase_s)
      PH_IDLE: ;
      PH_RST_PRES: begin
        if (!line_level_i) begin
          cnt_d   = '0;
          phase_d = PH_RST_HOLD;
        end
      end
      PH_RST_HIGH: begin
        if (line_level_i) begin
          cnt_d   = '0;
          phase_d = PH_RST_TAIL;
        end
      end
      PH_RST_LOW, PH_RST_WAIT, PH_RST_HOLD, PH_RST_TAIL,
      PH_WR_LOW, PH_WR_REL, PH_RD_LOW, PH_RD_WAIT, PH_RD_TAIL: begin
        cnt_d = fin ? '0 : cnt_inc;
        if (fin) begin
          case (phase_s)
            PH_RST_LOW:  phase_d = PH_RST_WAIT;
            PH_RST_WAIT: phase_d = PH_RST_PRES;
            PH_RST_HOLD: phase_d = PH_RST_HIGH;
            PH_RST_TAIL: begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
            PH_WR_LOW:   phase_d = PH_WR_REL;
            PH_WR_REL: begin
              sb_d = {1'b0, sb_s[ByteW-1:1]};
              if (bidx_s == '1) begin
                bidx_d  = '0;
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                bidx_d  = bidx_s + BitIdxW'(1);
                phase_d = PH_WR_LOW;
              end
            end
            PH_RD_LOW:   phase_d = PH_RD_WAIT;
            PH_RD_WAIT: begin
              sb_d[bidx_s] = sb_s[bidx_s] | line_level_i;
              phase_d      = PH_RD_TAIL;
            end
            PH_RD_TAIL: begin
              if (bidx_s == '1) begin
                bidx_d  = '0;
                asm_d   = sb_s;
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                bidx_d  = bidx_s + BitIdxW'(1);
                phase_d = PH_RD_LOW;
              end
            end
            default: phase_d = phase_s;
          endcase
        end
      end
      default: begin
        phase_d = PH_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      bidx_q  <= '0;
      sb_q    <= '0;
      asm_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bidx_q  <= bidx_d;
      sb_q    <= sb_d;
      asm_q   <= asm_d;
    end
  end

  assign res_o = '{drive_low: drive, busy_res: busy, done_res: done, read_byte: asm_d};

endmodule

>>> rtl/obm_out.sv
// Result register: holds one result word and throttles the input side.
module obm_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  obm_pkg::res_t res_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output obm_pkg::res_t res_o
);
  import obm_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;
  logic take;

  // Accept while empty or while the held word leaves this cycle.
  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
